FILE: rtl/lzrle_pkg.sv
package lzrle_pkg;

   localparam int HIST_DEPTH = 8192;
   localparam int HIST_AW = $clog2(HIST_DEPTH);
   localparam int COUNT_BITS = 24;
   localparam int RAW_BITS = 24;
   localparam int RUN_BITS = 13;

   typedef enum logic [2:0] {
      PH_BOUNDARY,
      PH_FLAG_LO,
      PH_RLE_CHAR,
      PH_LONG_COUNT,
      PH_LONG_CHAR,
      PH_DIST,
      PH_COPY_LEN
   } phase_type;

   localparam logic [3:0] CODE_RLE = 4'd0;
   localparam logic [3:0] CODE_LONG = 4'd1;
   localparam logic [3:0] CODE_TABLE = 4'd2;
   localparam logic [3:0] CODE_ZERO = 4'd14;
   localparam logic [3:0] CODE_LONG_COPY = 4'd15;

   typedef struct packed {
      logic       kind;
      logic [7:0] packed_byte;
      logic       last_packed;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       run_pending;
      logic       finished;
      logic       failed;
   } rsp_type;

   function automatic logic [7:0] run_table(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0: v = 8'h00;
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h03;
         4'd4: v = 8'h04;
         4'd5: v = 8'h08;
         4'd6: v = 8'h10;
         4'd7: v = 8'h20;
         4'd8: v = 8'h40;
         4'd9: v = 8'h55;
         4'd10: v = 8'h60;
         4'd11: v = 8'h80;
         4'd12: v = 8'haa;
         4'd13: v = 8'hc0;
         4'd14: v = 8'he0;
         default: v = 8'hff;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/lzrle_req_if.sv
interface lzrle_req_if;
   import lzrle_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lzrle_rsp_if.sv
interface lzrle_rsp_if;
   import lzrle_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lzrle_core.sv
// decoder core: parser state, run state and history memory.
// the history read is synchronous; the read address for the next word is
// computed from next state so the data is there when the drain word arrives.
module lzrle_core
   import lzrle_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [RAW_BITS-1:0]  raw_size,
   input  logic                 step,
   input  req_type              word,
   output rsp_type              result
);

   logic [7:0] hist_mem [HIST_DEPTH];
   logic [7:0] rd_data_ff;
   logic       hist_we;
   logic [HIST_AW-1:0] hist_wa;
   logic [7:0] hist_wd;
   logic [HIST_AW-1:0] rd_addr;

   logic [COUNT_BITS-1:0] wcount_ff, wcount_in;
   logic [15:0] flag_ff, flag_in;
   logic [4:0]  flag_left_ff, flag_left_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  head_ff, head_in;
   logic [7:0]  extra_ff, extra_in;
   logic [RUN_BITS-1:0] remain_ff, remain_in;
   logic [12:0] dist_ff, dist_in;
   logic [7:0]  fill_ff, fill_in;
   logic        copy_ff, copy_in;
   logic        err_ff, err_in;
   logic        ended_ff, ended_in;
   // last written byte, for distance-one style forwarding
   logic [7:0]  last_wd_ff;
   logic        fwd_ff;

   logic        br_go;
   logic [12:0] br_count;
   logic [7:0]  br_value;
   logic        br_copy;
   logic [12:0] br_dist;
   logic [7:0]  drain_v;

   always_comb begin
      logic [3:0]  code;
      logic [3:0]  low;
      logic [11:0] wide;
      logic        put;
      logic [7:0]  put_v;
      code = head_ff[7:4];
      low = head_ff[3:0];
      wide = {extra_ff, low};
      wcount_in = wcount_ff;
      flag_in = flag_ff;
      flag_left_in = flag_left_ff;
      phase_in = phase_ff;
      head_in = head_ff;
      extra_in = extra_ff;
      remain_in = remain_ff;
      dist_in = dist_ff;
      fill_in = fill_ff;
      copy_in = copy_ff;
      err_in = err_ff;
      ended_in = ended_ff;
      put = 1'b0;
      put_v = 8'h00;
      br_go = 1'b0;
      br_count = '0;
      br_value = 8'h00;
      br_copy = 1'b0;
      br_dist = '0;
      drain_v = copy_ff ? (fwd_ff ? last_wd_ff : rd_data_ff) : fill_ff;
      result = '0;
      if (step) begin
         if (!err_ff) begin
            if (word.kind) begin
               if (remain_ff != '0) begin
                  put = 1'b1;
                  put_v = drain_v;
                  remain_in = remain_ff - 1'b1;
               end
            end else if (!ended_ff) begin
               if (remain_ff != '0) begin
                  err_in = 1'b1;
                  remain_in = '0;
               end else begin
                  ended_in = word.last_packed;
                  case (phase_ff)
                     PH_BOUNDARY: begin
                        if (wcount_ff < COUNT_BITS'(raw_size)) begin
                           if (flag_left_ff == '0) begin
                              flag_in = {word.packed_byte, 8'h00};
                              phase_in = PH_FLAG_LO;
                           end else begin
                              flag_in = {flag_ff[14:0], 1'b0};
                              flag_left_in = flag_left_ff - 1'b1;
                              if (!flag_ff[15]) begin
                                 put = 1'b1;
                                 put_v = word.packed_byte;
                              end else begin
                                 head_in = word.packed_byte;
                                 case (word.packed_byte[7:4])
                                    CODE_RLE: phase_in = PH_RLE_CHAR;
                                    CODE_ZERO: begin
                                       br_go = 1'b1;
                                       br_count = 13'(word.packed_byte[3:0]) + 13'd3;
                                    end
                                    CODE_LONG: phase_in = PH_LONG_COUNT;
                                    CODE_TABLE: begin
                                       br_go = 1'b1;
                                       br_count = 13'd2;
                                       br_value = run_table(word.packed_byte[3:0]);
                                    end
                                    default: phase_in = PH_DIST;
                                 endcase
                              end
                           end
                        end
                     end
                     PH_FLAG_LO: begin
                        flag_in = {flag_ff[15:8], word.packed_byte};
                        flag_left_in = 5'd16;
                        phase_in = PH_BOUNDARY;
                     end
                     PH_RLE_CHAR: begin
                        br_go = 1'b1;
                        br_count = 13'(low) + 13'd3;
                        br_value = word.packed_byte;
                     end
                     PH_LONG_COUNT: begin
                        extra_in = word.packed_byte;
                        phase_in = PH_LONG_CHAR;
                     end
                     PH_LONG_CHAR: begin
                        br_go = 1'b1;
                        br_count = 13'(wide) + 13'd19;
                        br_value = word.packed_byte;
                     end
                     PH_DIST: begin
                        extra_in = word.packed_byte;
                        if (code == CODE_LONG_COPY) begin
                           phase_in = PH_COPY_LEN;
                        end else begin
                           br_go = 1'b1;
                           br_count = 13'(code);
                           br_copy = 1'b1;
                           br_dist = 13'({word.packed_byte, low}) + 13'd3;
                        end
                     end
                     PH_COPY_LEN: begin
                        br_go = 1'b1;
                        br_count = 13'(word.packed_byte) + 13'd14;
                        br_copy = 1'b1;
                        br_dist = 13'(wide) + 13'd3;
                     end
                     default: phase_in = PH_BOUNDARY;
                  endcase
                  if (br_go) begin
                     phase_in = PH_BOUNDARY;
                     if ((br_copy && COUNT_BITS'(br_dist) > wcount_ff) ||
                         ({1'b0, wcount_ff} + (COUNT_BITS+1)'(br_count) >
                          (COUNT_BITS+1)'(raw_size))) begin
                        err_in = 1'b1;
                        remain_in = '0;
                     end else begin
                        remain_in = br_count;
                        fill_in = br_value;
                        copy_in = br_copy;
                        dist_in = br_dist;
                     end
                  end
               end
            end
            if (put) begin
               wcount_in = wcount_ff + 1'b1;
            end
            if (!err_in && ended_in && remain_in == '0 &&
                (phase_in != PH_BOUNDARY || wcount_in < COUNT_BITS'(raw_size))) begin
               err_in = 1'b1;
            end
         end
         result.byte_valid = put;
         result.out_byte = put ? put_v : 8'h00;
         result.run_pending = remain_in != '0;
         result.finished = !err_in && remain_in == '0 && phase_in == PH_BOUNDARY &&
                           wcount_in >= COUNT_BITS'(raw_size);
         result.failed = err_in;
      end
      hist_we = put;
      hist_wa = wcount_ff[HIST_AW-1:0];
      hist_wd = put_v;
      rd_addr = wcount_in[HIST_AW-1:0] - dist_in[HIST_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      rd_data_ff <= hist_mem[rd_addr];
      last_wd_ff <= hist_wd;
      // the entry being written this cycle is the one the next drain needs
      fwd_ff <= hist_we && (rd_addr == hist_wa);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff <= '0;
         flag_ff <= '0;
         flag_left_ff <= '0;
         phase_ff <= PH_BOUNDARY;
         head_ff <= '0;
         extra_ff <= '0;
         remain_ff <= '0;
         dist_ff <= '0;
         fill_ff <= '0;
         copy_ff <= 1'b0;
         err_ff <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         wcount_ff <= wcount_in;
         flag_ff <= flag_in;
         flag_left_ff <= flag_left_in;
         phase_ff <= phase_in;
         head_ff <= head_in;
         extra_ff <= extra_in;
         remain_ff <= remain_in;
         dist_ff <= dist_in;
         fill_ff <= fill_in;
         copy_ff <= copy_in;
         err_ff <= err_in;
         ended_ff <= ended_in;
      end
   end

endmodule

FILE: rtl/lzrle_outq.sv
// two-entry result queue so input keeps flowing while the sink stalls, until both entries are full
module lzrle_outq
   import lzrle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    has_room,
   lzrle_rsp_if.source rsp
);

   rsp_type    slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   always_comb begin
      pop = rsp.valid && rsp.ready;
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      has_room = (cnt_ff != 2'd2) || rsp.ready;
      rsp.valid = cnt_ff != 2'd0;
      rsp.data = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/lz_rle_flagged_decompressor_core.sv
// Flagged LZ77/RLE byte decompressor. Each request word is a packed byte or a
// drain tick and yields exactly one response word, one word per clock while
// the response side keeps up; a decoded byte goes through the 8192-byte
// history memory, whose one synchronous read per cycle is prefetched and
// forwarded from the write path. A two-word response queue lets requests keep
// arriving while the response side stalls, until both queue entries are full.
// Write csr_raw_size only while idle. The history needs no
// clearing after reset.
module lz_rle_flagged_decompressor_core
   import lzrle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [RAW_BITS-1:0] csr_raw_size,
   lzrle_req_if.sink           req,
   lzrle_rsp_if.source         rsp
);

   logic [RAW_BITS-1:0] raw_size_ff;
   logic    has_room;
   logic    step;
   rsp_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_size_ff <= '0;
      end else if (csr_we) begin
         raw_size_ff <= csr_raw_size;
      end
   end

   assign req.ready = has_room;
   assign step = req.valid && has_room;

   lzrle_core u_core (
      .clock    (clock),
      .reset    (reset),
      .raw_size (raw_size_ff),
      .step     (step),
      .word     (req.data),
      .result   (result)
   );

   lzrle_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (result),
      .has_room  (has_room),
      .rsp       (rsp)
   );

`ifndef ASSERT_OFF
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.failed && rsp.ready |=> !rsp.valid || rsp.data.failed)
      else $error("failed flag dropped");
   a_fin_excl: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.data.finished && rsp.data.failed))
      else $error("finished and failed together");
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data.byte_valid |-> rsp.data.out_byte == 8'h00)
      else $error("stray output byte");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import lzrle_pkg::*;

   // token kinds for the stream builder
   localparam int K_RLE   = 0;
   localparam int K_ZERO  = 1;
   localparam int K_LONG  = 2;
   localparam int K_TABLE = 3;
   localparam int K_COPY  = 4;
   localparam int K_LCOPY = 5;
   localparam int K_LIT   = 6;

   localparam int ENDING_CLEAN   = 0;
   localparam int ENDING_OVERRUN = 1;
   localparam int ENDING_BADDIST = 2;
   localparam int ENDING_PENDING = 3;
   localparam int ENDING_TRUNC   = 4;

   localparam logic [RAW_BITS-1:0] RAW_MAX = '1;
   localparam logic [7:0] FILL_VALS [16] = '{
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h08, 8'h10, 8'h20,
      8'h40, 8'h55, 8'h60, 8'h80, 8'haa, 8'hc0, 8'he0, 8'hff};

   typedef struct {
      bit                  is_cfg;
      logic [RAW_BITS-1:0] cfg_val;
      req_type             w;
   } stim_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [RAW_BITS-1:0] csr_raw_size;

   lzrle_req_if req_if ();
   lzrle_rsp_if rsp_if ();

   lz_rle_flagged_decompressor_core dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_raw_size (csr_raw_size),
      .req          (req_if),
      .rsp          (rsp_if)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   stim_type stim_q [$];
   stim_type ph_q [$];
   rsp_type  want_q [$];

   int mismatches = 0;
   int words_in = 0;
   int words_out = 0;
   int bytes_out = 0;
   int ending_kind;

   // ---------------------------------------------------------------- predictor
   logic [7:0]          hist [HIST_DEPTH];
   logic [RAW_BITS-1:0] m_raw = '0;
   logic [COUNT_BITS-1:0] m_written = '0;
   logic [15:0]         m_fw = '0;
   int                  m_fbits = 0;
   phase_type           m_phase = PH_BOUNDARY;
   logic [7:0]          m_head = '0;
   logic [7:0]          m_extra = '0;
   int                  m_left = 0;
   int                  m_dist = 0;
   logic [7:0]          m_fill = '0;
   bit                  m_copy = 0;
   bit                  m_err = 0;
   bit                  m_ended = 0;

   task automatic m_fail();
      m_err = 1;
      m_left = 0;
   endtask

   task automatic m_put(input logic [7:0] b);
      hist[m_written % HIST_DEPTH] = b;
      m_written = m_written + 1'b1;
   endtask

   task automatic m_start_run(input int cnt, input logic [7:0] v, input bit cp, input int d);
      m_phase = PH_BOUNDARY;
      if (cp && d > int'(m_written)) begin
         m_fail();
      end else if (longint'(m_written) + cnt > longint'(m_raw)) begin
         m_fail();
      end else begin
         m_left = cnt & 16'h1fff;
         m_fill = v;
         m_copy = cp;
         m_dist = d & 16'h1fff;
      end
   endtask

   task automatic m_parse(input logic [7:0] b, inout rsp_type r);
      logic [3:0] code;
      logic [3:0] lo;
      int wide;
      bit fb;
      code = m_head[7:4];
      lo = m_head[3:0];
      wide = {m_extra, lo};
      case (m_phase)
         PH_BOUNDARY: begin
            if (m_written >= m_raw) return;
            if (m_fbits == 0) begin
               m_fw = {b, 8'h00};
               m_phase = PH_FLAG_LO;
               return;
            end
            fb = m_fw[15];
            m_fw = m_fw << 1;
            m_fbits--;
            if (!fb) begin
               m_put(b);
               r.byte_valid = 1'b1;
               r.out_byte = b;
            end else begin
               m_head = b;
               if (b[7:4] == CODE_RLE) m_phase = PH_RLE_CHAR;
               else if (b[7:4] == CODE_ZERO) m_start_run(b[3:0] + 3, 8'h00, 0, 0);
               else if (b[7:4] == CODE_LONG) m_phase = PH_LONG_COUNT;
               else if (b[7:4] == CODE_TABLE) m_start_run(2, FILL_VALS[b[3:0]], 0, 0);
               else m_phase = PH_DIST;
            end
         end
         PH_FLAG_LO: begin
            m_fw = m_fw | b;
            m_fbits = 16;
            m_phase = PH_BOUNDARY;
         end
         PH_RLE_CHAR: m_start_run(lo + 3, b, 0, 0);
         PH_LONG_COUNT: begin
            m_extra = b;
            m_phase = PH_LONG_CHAR;
         end
         PH_LONG_CHAR: m_start_run(wide + 19, b, 0, 0);
         PH_DIST: begin
            m_extra = b;
            if (code == CODE_LONG_COPY) m_phase = PH_COPY_LEN;
            else m_start_run(code, 8'h00, 1, {b, lo} + 3);
         end
         PH_COPY_LEN: m_start_run(b + 14, 8'h00, 1, wide + 3);
         default: m_phase = PH_BOUNDARY;
      endcase
   endtask

   task automatic decode_word(input req_type w);
      rsp_type r;
      logic [7:0] v;
      r = '0;
      if (!m_err) begin
         if (w.kind) begin
            if (m_left != 0) begin
               v = m_fill;
               if (m_copy)
                  v = hist[(int'(m_written % HIST_DEPTH) + HIST_DEPTH - m_dist % HIST_DEPTH)
                           % HIST_DEPTH];
               m_put(v);
               m_left--;
               r.byte_valid = 1'b1;
               r.out_byte = v;
            end
         end else if (!m_ended) begin
            if (m_left != 0) begin
               m_fail();
            end else begin
               m_ended = w.last_packed;
               m_parse(w.packed_byte, r);
            end
         end
         if (!m_err && m_ended && m_left == 0 &&
             (m_phase != PH_BOUNDARY || m_written < m_raw))
            m_fail();
      end
      r.run_pending = (m_left != 0);
      r.finished = !m_err && m_left == 0 && m_phase == PH_BOUNDARY && m_written >= m_raw;
      r.failed = m_err;
      want_q.push_back(r);
   endtask

   // ---------------------------------------------------------------- stream builder
   int          g_written = 0;
   int          g_fbits = 0;
   logic [15:0] g_fw = '0;

   task automatic push_pk(input logic [7:0] b, input bit last = 0);
      stim_type s;
      s.is_cfg = 0;
      s.cfg_val = '0;
      s.w.kind = 1'b0;
      s.w.packed_byte = b;
      s.w.last_packed = last;
      ph_q.push_back(s);
   endtask

   task automatic push_drain(input int n);
      stim_type s;
      s.is_cfg = 0;
      s.cfg_val = '0;
      s.w.kind = 1'b1;
      s.w.last_packed = 1'($urandom);
      for (int i = 0; i < n; i++) begin
         s.w.packed_byte = 8'($urandom);
         ph_q.push_back(s);
      end
   endtask

   task automatic set_flags(input logic [15:0] w);
      push_pk(w[15:8]);
      push_pk(w[7:0]);
      g_fw = w;
      g_fbits = 16;
   endtask

   // one flag bit's worth of stream, with the drain ticks its run needs
   task automatic gen_step(input int kind, input int p1 = -1, input int p2 = -1);
      int k, lo, n, d, mx, ext;
      logic [11:0] enc;
      bit fb;
      if (g_fbits == 0) set_flags(16'($urandom));
      fb = g_fw[15];
      g_fw = g_fw << 1;
      g_fbits--;
      if (!fb) begin
         push_pk((kind == K_LIT && p1 >= 0) ? 8'(p1) : 8'($urandom));
         g_written++;
         if ($urandom_range(0, 7) == 0) push_drain(1);
         return;
      end
      k = (kind < 0 || kind == K_LIT) ? $urandom_range(K_RLE, K_LCOPY) : kind;
      if ((k == K_COPY || k == K_LCOPY) && g_written < 3) k = K_ZERO;
      lo = (p1 < 0) ? $urandom_range(0, 15) : p1;
      mx = (g_written < 4098) ? g_written : 4098;
      case (k)
         K_RLE: begin
            push_pk({CODE_RLE, 4'(lo)});
            push_pk(8'($urandom));
            n = lo + 3;
         end
         K_ZERO: begin
            push_pk({CODE_ZERO, 4'(lo)});
            n = lo + 3;
         end
         K_LONG: begin
            ext = (p2 < 0) ? $urandom_range(0, 2) : p2;
            push_pk({CODE_LONG, 4'(lo)});
            push_pk(8'(ext));
            push_pk(8'($urandom));
            n = (ext << 4 | lo) + 19;
         end
         K_TABLE: begin
            push_pk({CODE_TABLE, 4'(lo)});
            n = 2;
         end
         K_COPY: begin
            n = (p1 < 0) ? $urandom_range(3, 13) : p1;
            d = (p2 < 0) ? $urandom_range(3, mx) : p2;
            enc = 12'(d - 3);
            push_pk({4'(n), enc[3:0]});
            push_pk(enc[11:4]);
         end
         default: begin
            ext = (p1 >= 0) ? p1 : ($urandom_range(0, 15) == 0 ? $urandom_range(0, 255)
                                                                : $urandom_range(0, 20));
            d = (p2 < 0) ? $urandom_range(3, mx) : p2;
            enc = 12'(d - 3);
            push_pk({CODE_LONG_COPY, enc[3:0]});
            push_pk(enc[11:4]);
            push_pk(8'(ext));
            n = ext + 14;
         end
      endcase
      g_written += n;
      push_drain(n + ($urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : 0));
   endtask

   task automatic push_cfg(input logic [RAW_BITS-1:0] v);
      stim_type s;
      s.is_cfg = 1;
      s.cfg_val = v;
      s.w = '0;
      stim_q.push_back(s);
   endtask

   task automatic close_phase(input logic [RAW_BITS-1:0] raw);
      push_cfg(raw);
      foreach (ph_q[i]) stim_q.push_back(ph_q[i]);
      ph_q.delete();
   endtask

   // stray words between phases; packed bytes never carry the last mark here
   task automatic push_noise(input int n);
      stim_type s;
      s.is_cfg = 0;
      s.cfg_val = '0;
      for (int i = 0; i < n; i++) begin
         s.w.kind = 1'($urandom);
         s.w.packed_byte = 8'($urandom);
         s.w.last_packed = s.w.kind ? 1'($urandom) : 1'b0;
         stim_q.push_back(s);
      end
   endtask

   task automatic build_stream();
      int d;
      logic [11:0] enc;
      // raw_size still 0: every packed byte is surplus
      push_noise(6);
      set_flags(16'h3fff);
      gen_step(K_LIT, 8'h00);
      gen_step(K_LIT, 8'hff);
      gen_step(K_RLE, 0);
      gen_step(K_RLE, 15);
      gen_step(K_ZERO, 0);
      gen_step(K_ZERO, 15);
      gen_step(K_LONG, 0, 0);
      gen_step(K_LONG, 15, 2);
      gen_step(K_TABLE, 0);
      gen_step(K_TABLE, 15);
      gen_step(K_TABLE, 9);
      gen_step(K_COPY, 3, 3);
      gen_step(K_COPY, 13);
      gen_step(K_LCOPY, 0, 3);
      gen_step(K_LCOPY, 255);
      gen_step(K_COPY);
      close_phase(RAW_BITS'(g_written));
      push_noise(4);
      for (int p = 0; p < 7; p++) begin
         for (int j = 0; j < 7; j++) gen_step(-1);
         if (p == 3) begin
            push_cfg(RAW_MAX);
            foreach (ph_q[i]) stim_q.push_back(ph_q[i]);
            ph_q.delete();
            push_cfg(RAW_BITS'(g_written));
         end else begin
            close_phase(RAW_BITS'(g_written));
         end
         push_noise($urandom_range(0, 3));
      end
      ending_kind = $urandom_range(ENDING_CLEAN, ENDING_TRUNC);
      if (ending_kind == ENDING_BADDIST && g_written >= 4095) ending_kind = ENDING_TRUNC;
      if (ending_kind == ENDING_CLEAN) begin
         for (int j = 0; j < 12; j++) gen_step(-1);
         for (int i = ph_q.size() - 1; i >= 0; i--) begin
            if (ph_q[i].w.kind == 1'b0) begin
               ph_q[i].w.last_packed = 1'b1;
               break;
            end
         end
         close_phase(RAW_BITS'(g_written));
      end else begin
         while (g_fbits > 0) gen_step(-1);
         set_flags(16'hffff);
         case (ending_kind)
            ENDING_OVERRUN: begin
               push_pk({CODE_ZERO, 4'hf});
               push_drain(4);
               close_phase(RAW_BITS'(g_written + 2));
            end
            ENDING_BADDIST: begin
               d = g_written + 1;
               enc = 12'(d - 3);
               push_pk({4'd3, enc[3:0]});
               push_pk(enc[11:4]);
               push_drain(3);
               close_phase(RAW_BITS'(g_written + 100));
            end
            ENDING_PENDING: begin
               push_pk({CODE_ZERO, 4'hf});
               push_drain(2);
               push_pk(8'($urandom));
               push_drain(3);
               close_phase(RAW_BITS'(g_written + 100));
            end
            default: begin
               push_pk({CODE_LONG, 4'h0}, 1'b1);
               close_phase(RAW_BITS'(g_written + 100));
            end
         endcase
      end
      push_noise(40);
   endtask

   // ---------------------------------------------------------------- driver
   int quiet;
   int gap_left;
   int burst_left;
   bit present;
   bit we;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
         csr_we <= 1'b0;
         csr_raw_size <= '0;
         quiet = 0;
         gap_left = 0;
         burst_left = 1;
      end else begin
         present = 0;
         we = 0;
         if (req_if.valid && req_if.ready) begin
            decode_word(stim_q[0].w);
            stim_q.pop_front();
            words_in++;
         end else if (req_if.valid) begin
            present = 1;
         end
         if (!present && stim_q.size() > 0) begin
            if (stim_q[0].is_cfg) begin
               // wait for the block to go quiet before touching raw_size
               if (want_q.size() == 0) quiet++;
               else quiet = 0;
               if (quiet >= 8) begin
                  we = 1;
                  csr_raw_size <= stim_q[0].cfg_val;
                  m_raw = stim_q[0].cfg_val;
                  stim_q.pop_front();
                  quiet = 0;
               end
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               present = 1;
               req_if.data <= stim_q[0].w;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_if.valid <= present;
         csr_we <= we;
      end
   end

   // ---------------------------------------------------------------- receiver
   logic [15:0] stall_pat;
   int          hold_cnt;
   bit          held;
   bit          rdy;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_pat = 16'hffff;
         hold_cnt = 0;
         held = 0;
      end else begin
         if (hold_cnt > 0) begin
            hold_cnt--;
            rdy = 0;
         end else if (!held && words_out >= 500) begin
            // long back-pressure so the block fills and stalls its input
            held = 1;
            hold_cnt = 300;
            rdy = 0;
         end else begin
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            rdy = stall_pat[15];
            if ($urandom_range(0, 63) == 0) begin
               stall_pat = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
               if (stall_pat == 16'h0000) stall_pat = 16'h5555;
            end
         end
         rsp_if.ready <= rdy;
      end
   end

   // ---------------------------------------------------------------- monitor
   rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         words_out++;
         if (rsp_if.data.byte_valid) bytes_out++;
         if (want_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected word %h", rsp_if.data);
         end else begin
            want = want_q.pop_front();
            if (rsp_if.data.byte_valid !== want.byte_valid ||
                rsp_if.data.out_byte !== want.out_byte ||
                rsp_if.data.run_pending !== want.run_pending ||
                rsp_if.data.finished !== want.finished ||
                rsp_if.data.failed !== want.failed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: word %0d valid/byte/pend/fin/fail exp %b/%h/%b/%b/%b got %b/%h/%b/%b/%b",
                           words_out, want.byte_valid, want.out_byte, want.run_pending,
                           want.finished, want.failed, rsp_if.data.byte_valid,
                           rsp_if.data.out_byte, rsp_if.data.run_pending,
                           rsp_if.data.finished, rsp_if.data.failed);
            end
         end
      end
   end

   // ---------------------------------------------------------------- run control
   initial begin
      reset = 1'b1;
      build_stream();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0 || want_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (want_q.size() != 0) mismatches++;
      $display("checked %0d words, %0d decoded bytes, %0d stream bytes built",
               words_out, bytes_out, g_written);
      $display("stream ending kind %0d, final failed flag %0b", ending_kind, m_err);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
rtl/lzrle_pkg.sv
rtl/lzrle_req_if.sv
rtl/lzrle_rsp_if.sv
rtl/lzrle_core.sv
rtl/lzrle_outq.sv
rtl/lz_rle_flagged_decompressor_core.sv
tb/tb.sv
